// ===== sv/bts_pkg.sv =====
// Shared types and constants for the bilinear texel sampler.
// No dependencies; compile before the interfaces and the top level.
package bts_pkg;

  localparam int TEXEL_W       = 32;
  localparam int BYTE_W        = 8;
  localparam int NUM_CH        = 4;
  localparam int NUM_NBR       = 4;
  localparam int COORD_W       = 15;
  localparam int WADDR_W       = 14;
  localparam int CFG_W         = 8;
  localparam int TEX_WIDTH_RST = 128;

  typedef logic [0:0] opcode_t;

  localparam opcode_t OP_WRITE  = 1'b0;
  localparam opcode_t OP_SAMPLE = 1'b1;

endpackage

// ===== sv/bts_req_if.sv =====
// Request channel of the bilinear texel sampler: texel writes and samples.
// Depends on bts_pkg.
interface bts_req_if import bts_pkg::*; ();
  logic                 valid;
  logic                 ready;
  opcode_t              opcode;
  logic [WADDR_W-1:0]   write_address;
  logic [TEXEL_W-1:0]   write_texel;
  logic [COORD_W-1:0]   sample_x;
  logic [COORD_W-1:0]   sample_y;

  modport source (output valid, opcode, write_address, write_texel, sample_x, sample_y,
                  input ready);
  modport sink   (input valid, opcode, write_address, write_texel, sample_x, sample_y,
                  output ready);
endinterface

// ===== sv/bts_rsp_if.sv =====
// Result channel of the bilinear texel sampler: one filtered texel per sample.
// Depends on bts_pkg.
interface bts_rsp_if import bts_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [TEXEL_W-1:0] filtered_texel;

  modport source (output valid, filtered_texel, input ready);
  modport sink   (input valid, filtered_texel, output ready);
endinterface

// ===== sv/bts_cfg_if.sv =====
// Configuration write channel of the bilinear texel sampler (texture width).
// Depends on bts_pkg.
interface bts_cfg_if import bts_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] tex_width;

  modport source (output valid, tex_width, input ready);
  modport sink   (input valid, tex_width, output ready);
endinterface

// ===== sv/bilinear_texel_sampler.sv =====
// Bilinear RGBA8 texel sampler: six-stage pipeline around a replicated texel store.
// Depends on bts_pkg, bts_req_if, bts_rsp_if and bts_cfg_if.
//
//   channel   direction  payload                                            handshake
//   in_req    sink       opcode, write_address, write_texel, sample_x/y     valid/ready
//   out_rsp   source     filtered_texel                                     valid/ready
//   cfg_wr    sink       tex_width                                          valid/ready
//
// One item enters per clock unless out_rsp stalls; a sample's result is registered in stage 6.
// A write item takes the same slots and yields no result; it lands in the store at the
// memory stage, so later samples see it and earlier ones do not.
// The throughput limit is the store: two copies, each read at two ports, give four texels
// per clock. When out_rsp stalls the whole pipeline holds and in_req.ready drops.
// Reset (rst_n low at a clock edge) empties the pipeline, width = min(128, MAX_TEX_DIM).
module bilinear_texel_sampler
  import bts_pkg::*;
#(
  parameter int MAX_TEX_DIM = 128,
  parameter int FRAC_BITS   = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  bts_req_if.sink     in_req,
  bts_rsp_if.source   out_rsp,
  bts_cfg_if.sink     cfg_wr
);

  localparam int DEPTH = MAX_TEX_DIM * MAX_TEX_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(MAX_TEX_DIM);        // coordinate bits
  localparam int WW    = $clog2(MAX_TEX_DIM + 1);    // width value bits
  localparam int IW    = COORD_W - FRAC_BITS;        // integer part of a coordinate
  localparam int FW    = FRAC_BITS + 1;              // one weight factor, up to ONE
  localparam int WTW   = 2 * FRAC_BITS + 1;          // product of two factors
  localparam int PW    = WTW + BYTE_W;               // weighted byte
  localparam int SW    = PW + 2;                     // sum of four weighted bytes
  localparam int ONE   = 1 << FRAC_BITS;
  localparam int RST_W = (TEX_WIDTH_RST > MAX_TEX_DIM) ? MAX_TEX_DIM : TEX_WIDTH_RST;

  // ---------------------------------------------------------------------------
  // Texture width register: clamp once at write time to 1..MAX_TEX_DIM.
  // ---------------------------------------------------------------------------
  logic [WW-1:0] eff_w_r, eff_w_nxt, eff_wm1_full;
  logic [CW-1:0] eff_wm1_r;
  logic [31:0]   cfg_val;

  assign cfg_wr.ready = 1'b1;
  assign cfg_val      = 32'(cfg_wr.tex_width);

  always_comb begin
    if (cfg_val == 32'd0) begin
      eff_w_nxt = WW'(1);
    end else if (cfg_val > 32'(MAX_TEX_DIM)) begin
      eff_w_nxt = WW'(MAX_TEX_DIM);
    end else begin
      eff_w_nxt = WW'(cfg_val);
    end
    eff_wm1_full = eff_w_nxt - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_w_r   <= WW'(RST_W);
      eff_wm1_r <= CW'(RST_W - 1);
    end else if (cfg_wr.valid && cfg_wr.ready) begin
      eff_w_r   <= eff_w_nxt;
      eff_wm1_r <= eff_wm1_full[CW-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: every stage advances together unless the result waits.
  // ---------------------------------------------------------------------------
  logic advance;
  logic accept;
  logic s6_smp_r;

  assign advance      = !s6_smp_r || out_rsp.ready;
  assign in_req.ready = advance;
  assign accept       = in_req.valid && advance;

  // ---------------------------------------------------------------------------
  // Stage 1: split coordinates, clamp integer parts, pick edge neighbors.
  // ---------------------------------------------------------------------------
  logic                 s1_smp_r, s1_wr_r;
  logic                 s1_smp_nxt, s1_wr_nxt;
  logic [CW-1:0]        s1_x0_r, s1_x1_r, s1_y0_r, s1_y1_r;
  logic [CW-1:0]        s1_x0_nxt, s1_x1_nxt, s1_y0_nxt, s1_y1_nxt;
  logic [FRAC_BITS-1:0] s1_fx_r, s1_fy_r;
  logic [AW-1:0]        s1_waddr_r;
  logic [TEXEL_W-1:0]   s1_wdata_r;
  logic [IW-1:0]        xi, yi;

  assign xi = in_req.sample_x[COORD_W-1:FRAC_BITS];
  assign yi = in_req.sample_y[COORD_W-1:FRAC_BITS];

  always_comb begin
    s1_smp_nxt = accept && (in_req.opcode == OP_SAMPLE);
    // Drop writes that fall outside the store.
    s1_wr_nxt  = accept && (in_req.opcode == OP_WRITE) &&
                 (32'(in_req.write_address) < 32'(DEPTH));
    s1_x0_nxt  = (32'(xi) > 32'(eff_wm1_r)) ? eff_wm1_r : CW'(xi);
    s1_y0_nxt  = (32'(yi) > 32'(eff_wm1_r)) ? eff_wm1_r : CW'(yi);
    s1_x1_nxt  = (s1_x0_nxt == eff_wm1_r) ? s1_x0_nxt : CW'(s1_x0_nxt + 1'b1);
    s1_y1_nxt  = (s1_y0_nxt == eff_wm1_r) ? s1_y0_nxt : CW'(s1_y0_nxt + 1'b1);
  end

  // ---------------------------------------------------------------------------
  // Stage 2: row offset of the upper row.
  // ---------------------------------------------------------------------------
  logic                 s2_smp_r, s2_wr_r;
  logic [AW-1:0]        s2_row0_r;
  logic                 s2_ystep_r;
  logic [CW-1:0]        s2_x0_r, s2_x1_r;
  logic [FRAC_BITS-1:0] s2_fx_r, s2_fy_r;
  logic [AW-1:0]        s2_waddr_r;
  logic [TEXEL_W-1:0]   s2_wdata_r;
  logic [CW+WW-1:0]     row0_full;

  assign row0_full = s1_y0_r * eff_w_r;

  // ---------------------------------------------------------------------------
  // Stage 3: four texel addresses and four weights.
  // ---------------------------------------------------------------------------
  logic                 s3_smp_r, s3_wr_r;
  logic [AW-1:0]        s3_addr_r [NUM_NBR];
  logic [AW-1:0]        addr_nxt  [NUM_NBR];
  logic [WTW-1:0]       s3_wt_r   [NUM_NBR];
  logic [WTW-1:0]       wt_nxt    [NUM_NBR];
  logic [AW-1:0]        s3_waddr_r;
  logic [TEXEL_W-1:0]   s3_wdata_r;
  logic [AW-1:0]        row1;
  logic [FW-1:0]        fx_w, fy_w, cfx_w, cfy_w;
  logic [2*FW-1:0]      wt_full [NUM_NBR];

  always_comb begin
    row1        = s2_ystep_r ? AW'(s2_row0_r + AW'(eff_w_r)) : s2_row0_r;
    addr_nxt[0] = AW'(s2_row0_r + AW'(s2_x0_r));
    addr_nxt[1] = AW'(s2_row0_r + AW'(s2_x1_r));
    addr_nxt[2] = AW'(row1 + AW'(s2_x0_r));
    addr_nxt[3] = AW'(row1 + AW'(s2_x1_r));
    fx_w        = FW'(s2_fx_r);
    fy_w        = FW'(s2_fy_r);
    cfx_w       = FW'(ONE) - fx_w;
    cfy_w       = FW'(ONE) - fy_w;
    wt_full[0]  = cfx_w * cfy_w;
    wt_full[1]  = fx_w * cfy_w;
    wt_full[2]  = cfx_w * fy_w;
    wt_full[3]  = fx_w * fy_w;
    for (int k = 0; k < NUM_NBR; k++) begin
      wt_nxt[k] = wt_full[k][WTW-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: texel store. Two copies, written together, each read at two ports.
  // ---------------------------------------------------------------------------
  logic [TEXEL_W-1:0] mem_a [DEPTH];
  logic [TEXEL_W-1:0] mem_b [DEPTH];
  logic [TEXEL_W-1:0] s4_t_r  [NUM_NBR];
  logic [WTW-1:0]     s4_wt_r [NUM_NBR];
  logic               s4_smp_r;
  logic               mem_we;

  assign mem_we = advance && s3_wr_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_a[s3_waddr_r] <= s3_wdata_r;
    end
    if (advance) begin
      s4_t_r[0] <= mem_a[s3_addr_r[0]];
      s4_t_r[1] <= mem_a[s3_addr_r[1]];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_b[s3_waddr_r] <= s3_wdata_r;
    end
    if (advance) begin
      s4_t_r[2] <= mem_b[s3_addr_r[2]];
      s4_t_r[3] <= mem_b[s3_addr_r[3]];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: weight every byte of every neighbor.
  // ---------------------------------------------------------------------------
  logic          s5_smp_r;
  logic [PW-1:0] s5_prod_r [NUM_CH][NUM_NBR];
  logic [PW-1:0] prod_nxt  [NUM_CH][NUM_NBR];

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      for (int k = 0; k < NUM_NBR; k++) begin
        prod_nxt[ch][k] = PW'(s4_wt_r[k]) * PW'(s4_t_r[k][BYTE_W*ch +: BYTE_W]);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 6: sum per channel and truncate; the weights total ONE squared, so the
  // result never exceeds one byte.
  // ---------------------------------------------------------------------------
  logic [TEXEL_W-1:0] s6_texel_r, texel_nxt;
  logic [SW-1:0]      sum_ch [NUM_CH];

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      sum_ch[ch] = SW'(s5_prod_r[ch][0]) + SW'(s5_prod_r[ch][1]) +
                   SW'(s5_prod_r[ch][2]) + SW'(s5_prod_r[ch][3]);
      texel_nxt[BYTE_W*ch +: BYTE_W] = sum_ch[ch][2*FRAC_BITS +: BYTE_W];
    end
  end

  assign out_rsp.valid          = s6_smp_r;
  assign out_rsp.filtered_texel = s6_texel_r;

  // ---------------------------------------------------------------------------
  // Valid bits: advance with the data, hold on a stall.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_smp_r <= 1'b0;
      s1_wr_r  <= 1'b0;
      s2_smp_r <= 1'b0;
      s2_wr_r  <= 1'b0;
      s3_smp_r <= 1'b0;
      s3_wr_r  <= 1'b0;
      s4_smp_r <= 1'b0;
      s5_smp_r <= 1'b0;
      s6_smp_r <= 1'b0;
    end else if (advance) begin
      s1_smp_r <= s1_smp_nxt;
      s1_wr_r  <= s1_wr_nxt;
      s2_smp_r <= s1_smp_r;
      s2_wr_r  <= s1_wr_r;
      s3_smp_r <= s2_smp_r;
      s3_wr_r  <= s2_wr_r;
      s4_smp_r <= s3_smp_r;
      s5_smp_r <= s4_smp_r;
      s6_smp_r <= s5_smp_r;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_x0_r    <= s1_x0_nxt;
      s1_x1_r    <= s1_x1_nxt;
      s1_y0_r    <= s1_y0_nxt;
      s1_y1_r    <= s1_y1_nxt;
      s1_fx_r    <= in_req.sample_x[FRAC_BITS-1:0];
      s1_fy_r    <= in_req.sample_y[FRAC_BITS-1:0];
      s1_waddr_r <= AW'(in_req.write_address);
      s1_wdata_r <= in_req.write_texel;

      s2_row0_r  <= AW'(row0_full);
      s2_ystep_r <= (s1_y1_r != s1_y0_r);
      s2_x0_r    <= s1_x0_r;
      s2_x1_r    <= s1_x1_r;
      s2_fx_r    <= s1_fx_r;
      s2_fy_r    <= s1_fy_r;
      s2_waddr_r <= s1_waddr_r;
      s2_wdata_r <= s1_wdata_r;

      for (int k = 0; k < NUM_NBR; k++) begin
        s3_addr_r[k] <= addr_nxt[k];
        s3_wt_r[k]   <= wt_nxt[k];
        s4_wt_r[k]   <= s3_wt_r[k];
      end
      s3_waddr_r <= s2_waddr_r;
      s3_wdata_r <= s2_wdata_r;

      for (int ch = 0; ch < NUM_CH; ch++) begin
        for (int k = 0; k < NUM_NBR; k++) begin
          s5_prod_r[ch][k] <= prod_nxt[ch][k];
        end
      end

      s6_texel_r <= texel_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  a_x_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    s1_smp_r |-> (s1_x1_r <= eff_wm1_r) &&
                 ((s1_x1_r == s1_x0_r) || (s1_x1_r == CW'(s1_x0_r + 1'b1))))
    else $error("x neighbor outside texture or not adjacent");

  a_y_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    s1_smp_r |-> (s1_y1_r <= eff_wm1_r) &&
                 ((s1_y1_r == s1_y0_r) || (s1_y1_r == CW'(s1_y0_r + 1'b1))))
    else $error("y neighbor outside texture or not adjacent");

  a_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
    s3_smp_r |-> (32'(s3_addr_r[3]) < 32'(DEPTH)) && (s3_addr_r[0] <= s3_addr_r[3]))
    else $error("texel address outside store");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    advance && s5_smp_r |=> s6_smp_r)
    else $error("sample lost between final stages");

endmodule
